@@ sv/n7seg_pkg.sv @@
package n7seg_pkg;

    localparam int MAG_W = 14;

    typedef logic [3:0]       digit_t;
    typedef logic [MAG_W-1:0] mag_t;
    typedef logic [7:0]       seg_t;

    typedef struct packed {
        digit_t digit;
        mag_t   rest;
    } split_t;

    localparam logic signed [15:0] CLAMP_HIGH = 16'sd9999;
    localparam logic signed [15:0] CLAMP_LOW  = -16'sd999;

    localparam mag_t UNIT_THOUSANDS = 14'd1000;
    localparam mag_t UNIT_HUNDREDS  = 14'd100;
    localparam mag_t UNIT_TENS      = 14'd10;

    localparam seg_t SEG_BLANK = 8'h00;

    localparam seg_t SEG_TABLE [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    // one decimal digit by parallel compares against the nine multiples of unit
    function automatic split_t split_digit(mag_t value, mag_t unit);
        split_t res;
        mag_t   step;
        res.digit = '0;
        res.rest  = value;
        for (int k = 1; k <= 9; k++)
        begin
            step = MAG_W'(k) * unit;
            if (value >= step)
            begin
                res.digit = 4'(k);
                res.rest  = value - step;
            end
        end
        return res;
    endfunction

    function automatic seg_t digit_pattern(digit_t d);
        seg_t p;
        if (d <= 4'd9)
            p = SEG_TABLE[d];
        else
            p = SEG_BLANK;
        return p;
    endfunction

endpackage

@@ sv/number_to_seven_segment_unit.sv @@
// number_to_seven_segment_unit
// converts a signed 16-bit number into four seven-segment patterns,
// leftmost digit first (bit0 segment a .. bit6 segment g, bit7 dp is 0 unless inverted)
// input channel: in_valid / in_stall carrying number_value and
// show_leading_zeros; output channel: out_valid / out_stall carrying the
// four pattern ports
// the number is clamped to -999..9999, the sign dropped, leading zeros blanked
// unless show_leading_zeros is set; the units digit is always shown
// config channel: cfg_valid / cfg_ready, cfg_data is the invert flag, which
// inverts every pattern; cfg_ready is always high
// each accepted input word passes registered stages in order: clamp,
// thousands digit, hundreds digit, tens and units digits, segment encode
// throughput is one word per cycle while out_stall is low; the digit extraction stages each hold
// one bank of compare-subtract units and pass valid bits along with data
// reset clears all valid bits and the invert flag; the pipeline comes out empty
// when out_stall is high, stages holding words stop and bubbles are squeezed
// out; in_stall rises once every stage is full, nothing is lost or repeated
module number_to_seven_segment_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] number_value,
    input  logic        show_leading_zeros,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  thousands_segments,
    output logic [7:0]  hundreds_segments,
    output logic [7:0]  tens_segments,
    output logic [7:0]  units_segments,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic invert_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic adv1, adv2, adv3, adv4, adv5;

    n7seg_pkg::mag_t   mag1_reg;
    logic              lz1_reg;

    n7seg_pkg::digit_t th2_reg;
    logic [9:0]        rem2_reg;
    logic              lz2_reg;

    n7seg_pkg::digit_t th3_reg, hu3_reg;
    logic [6:0]        rem3_reg;
    logic              lz3_reg;

    n7seg_pkg::digit_t th4_reg, hu4_reg, te4_reg, un4_reg;
    logic              lz4_reg;

    n7seg_pkg::seg_t   th5_reg, hu5_reg, te5_reg, un5_reg;

    logic signed [15:0] clamped;
    n7seg_pkg::mag_t    mag_next;
    n7seg_pkg::split_t  split_th, split_hu, split_te;
    n7seg_pkg::seg_t    th_next, hu_next, te_next, un_next;
    n7seg_pkg::seg_t    polarity;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            invert_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            invert_reg <= cfg_data;
    end

    // stage advance chain
    assign adv5     = !v5_reg || !out_stall;
    assign adv4     = !v4_reg || adv5;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
            if (adv5)
                v5_reg <= v4_reg;
        end
    end

    // clamp and magnitude
    always_comb
    begin
        clamped = $signed(number_value);
        if (clamped > n7seg_pkg::CLAMP_HIGH)
            clamped = n7seg_pkg::CLAMP_HIGH;
        else if (clamped < n7seg_pkg::CLAMP_LOW)
            clamped = n7seg_pkg::CLAMP_LOW;
        if (clamped < 16'sd0)
            mag_next = n7seg_pkg::MAG_W'(-clamped);
        else
            mag_next = n7seg_pkg::MAG_W'(clamped);
    end

    assign split_th = n7seg_pkg::split_digit(mag1_reg, n7seg_pkg::UNIT_THOUSANDS);
    assign split_hu = n7seg_pkg::split_digit(n7seg_pkg::MAG_W'(rem2_reg),
                                             n7seg_pkg::UNIT_HUNDREDS);
    assign split_te = n7seg_pkg::split_digit(n7seg_pkg::MAG_W'(rem3_reg),
                                             n7seg_pkg::UNIT_TENS);

    // blanking and polarity
    always_comb
    begin
        polarity = {8{invert_reg}};
        th_next  = n7seg_pkg::digit_pattern(th4_reg);
        hu_next  = n7seg_pkg::digit_pattern(hu4_reg);
        te_next  = n7seg_pkg::digit_pattern(te4_reg);
        un_next  = n7seg_pkg::digit_pattern(un4_reg);
        if (!lz4_reg && th4_reg == '0)
            th_next = n7seg_pkg::SEG_BLANK;
        if (!lz4_reg && th4_reg == '0 && hu4_reg == '0)
            hu_next = n7seg_pkg::SEG_BLANK;
        if (!lz4_reg && th4_reg == '0 && hu4_reg == '0 && te4_reg == '0)
            te_next = n7seg_pkg::SEG_BLANK;
        th_next = th_next ^ polarity;
        hu_next = hu_next ^ polarity;
        te_next = te_next ^ polarity;
        un_next = un_next ^ polarity;
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            mag1_reg <= mag_next;
            lz1_reg  <= show_leading_zeros;
        end
        if (adv2)
        begin
            th2_reg  <= split_th.digit;
            rem2_reg <= split_th.rest[9:0];
            lz2_reg  <= lz1_reg;
        end
        if (adv3)
        begin
            th3_reg  <= th2_reg;
            hu3_reg  <= split_hu.digit;
            rem3_reg <= split_hu.rest[6:0];
            lz3_reg  <= lz2_reg;
        end
        if (adv4)
        begin
            th4_reg <= th3_reg;
            hu4_reg <= hu3_reg;
            te4_reg <= split_te.digit;
            un4_reg <= split_te.rest[3:0];
            lz4_reg <= lz3_reg;
        end
        if (adv5)
        begin
            th5_reg <= th_next;
            hu5_reg <= hu_next;
            te5_reg <= te_next;
            un5_reg <= un_next;
        end
    end

    assign out_valid          = v5_reg;
    assign thousands_segments = th5_reg;
    assign hundreds_segments  = hu5_reg;
    assign tens_segments      = te5_reg;
    assign units_segments     = un5_reg;

endmodule
